// File: rtl/wtom_pkg.sv
package wtom_pkg;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	localparam logic [7:0] GAIN_RESET = 8'd200;

	typedef struct packed {
		logic              valid;
		logic signed [7:0] sample;
	} wtom_push_t;

	localparam logic [7:0] SINE_ROM [256] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd193, 8'd195,
		8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210, 8'd213, 8'd215,
		8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
		8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244,
		8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
		8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
		8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
		8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
		8'd245, 8'd244, 8'd242, 8'd241, 8'd240, 8'd238, 8'd236, 8'd235,
		8'd233, 8'd231, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd219,
		8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd206, 8'd203, 8'd201,
		8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd185, 8'd182, 8'd179,
		8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
		8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
		8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
		8'd103, 8'd100, 8'd97,  8'd94,  8'd91,  8'd88,  8'd85,  8'd82,
		8'd79,  8'd76,  8'd73,  8'd70,  8'd68,  8'd65,  8'd62,  8'd60,
		8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd45,  8'd42,  8'd40,
		8'd38,  8'd36,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd24,
		8'd22,  8'd20,  8'd19,  8'd17,  8'd15,  8'd14,  8'd13,  8'd11,
		8'd10,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd4,
		8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
		8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
		8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd17,  8'd19,  8'd20,
		8'd22,  8'd24,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd36,
		8'd38,  8'd40,  8'd42,  8'd45,  8'd47,  8'd49,  8'd52,  8'd54,
		8'd57,  8'd60,  8'd62,  8'd65,  8'd68,  8'd70,  8'd73,  8'd76,
		8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
		8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
	};

endpackage

// File: rtl/wtom_out_fifo.sv
module wtom_out_fifo
	import wtom_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  wtom_push_t        push,
	input  logic              pop,
	output logic              valid,
	output logic signed [7:0] sample
);

	logic signed [7:0] buf_q [OUT_DEPTH];
	logic [OUT_PW-1:0] wr_ptr_q;
	logic [OUT_PW-1:0] rd_ptr_q;
	logic [OUT_CW-1:0] count_q;
	logic              do_pop;

	assign valid  = (count_q != '0);
	assign do_pop = pop && valid;
	assign sample = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			buf_q[wr_ptr_q] <= push.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/wavetable_oscillator_mixer_unit.sv
// Channel | Direction | tvalid/tready      | Contents
// s       | in        | s_tvalid, s_tready | tuser: kind; tdata: voice, phase_step, volume
// m       | out       | m_tvalid, m_tready | tdata: sample, audio_word
//
// A tick reads the voice memories for voices 0 through NUM_VOICES-1, one voice per
// cycle, and holds s_tready low until the last voice is issued; a set-voice word
// is written to the parameter memory as it is accepted.
// Reset clears memory valid bits, not contents; unwritten voices read step 0, gain 200.
// Results queue in a four-word buffer; ticks stall once four are outstanding,
// so a stalled output never blocks until that buffer is full.
module wavetable_oscillator_mixer_unit
	import wtom_pkg::*;
#(
	parameter int NUM_VOICES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // voice[1:0], phase_step[33:2], volume[41:34], zero
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // sample[7:0], audio_word[39:8]
);

	localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int AW_EXT  = (VW > 2) ? VW : 2;
	localparam int MIX_W   = 9 + $clog2(NUM_VOICES);
	localparam int RECIP_W = 17;
	localparam int PROD_W  = MIX_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((65536 + NUM_VOICES - 1) / NUM_VOICES);
	localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);

	logic [1:0]  in_voice;
	logic [31:0] in_step;
	logic [7:0]  in_gain;
	logic        in_kind;
	logic        in_acc;
	logic        tick_acc;
	logic        set_acc;
	logic [AW_EXT-1:0] voice_x;
	logic [VW-1:0]     set_addr;

	assign in_voice = s_tdata[1:0];
	assign in_step  = s_tdata[33:2];
	assign in_gain  = s_tdata[41:34];
	assign in_kind  = s_tuser[0];
	assign voice_x  = AW_EXT'(in_voice);
	assign set_addr = voice_x[VW-1:0];

	logic              busy_q;
	logic [VW-1:0]     vcnt_q;
	logic [OUT_CW-1:0] outstanding_q;
	logic              can_tick;
	logic              out_pop;

	assign can_tick = (outstanding_q < OUT_CW'(OUT_DEPTH));
	assign s_tready = !busy_q && can_tick;
	assign in_acc   = s_tvalid && s_tready;
	assign tick_acc = in_acc && (in_kind == KIND_TICK);
	assign set_acc  = in_acc && (in_kind == KIND_SET) && (32'(in_voice) < NUM_VOICES);

	logic          iss_vld;
	logic [VW-1:0] iss_addr;

	assign iss_vld  = tick_acc || busy_q;
	assign iss_addr = busy_q ? vcnt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vcnt_q <= '0;
		end else if (iss_vld) begin
			busy_q <= (iss_addr != LAST_V);
			vcnt_q <= iss_addr + 1'b1;
		end
	end

	// voice memories: accumulators, and step with gain
	logic [31:0] acc_mem [NUM_VOICES];
	logic [39:0] prm_mem [NUM_VOICES];
	logic [NUM_VOICES-1:0] acc_vld_q;
	logic [NUM_VOICES-1:0] prm_vld_q;

	logic [31:0]   acc_rd_s1;
	logic [39:0]   prm_rd_s1;
	logic          acc_ok_s1;
	logic          prm_ok_s1;
	logic          v_s1;
	logic          first_s1;
	logic          last_s1;
	logic [VW-1:0] addr_s1;

	logic          fwd_vld_q;
	logic [VW-1:0] fwd_addr_q;
	logic [31:0]   fwd_data_q;

	logic [31:0] acc_old;
	logic [31:0] step_s1;
	logic [7:0]  gain_s1;
	logic [31:0] acc_new;

	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			acc_old = fwd_data_q;
		end else if (acc_ok_s1) begin
			acc_old = acc_rd_s1;
		end else begin
			acc_old = '0;
		end
		step_s1 = prm_ok_s1 ? prm_rd_s1[31:0] : '0;
		gain_s1 = prm_ok_s1 ? prm_rd_s1[39:32] : GAIN_RESET;
		acc_new = acc_old + step_s1;
	end

	always_ff @(posedge clk) begin
		acc_rd_s1 <= acc_mem[iss_addr];
		prm_rd_s1 <= prm_mem[iss_addr];
		acc_ok_s1 <= acc_vld_q[iss_addr];
		prm_ok_s1 <= prm_vld_q[iss_addr];
		addr_s1   <= iss_addr;
		if (v_s1) begin
			acc_mem[addr_s1] <= acc_new;
		end
		if (set_acc) begin
			prm_mem[set_addr] <= {in_gain, in_step};
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= acc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			prm_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (v_s1) begin
				acc_vld_q[addr_s1] <= 1'b1;
			end
			if (set_acc) begin
				prm_vld_q[set_addr] <= 1'b1;
			end
			fwd_vld_q <= v_s1;
		end
	end

	// voice datapath
	logic              v_s2, v_s3, v_s4, v_s5, v_s6;
	logic              first_s2, first_s3, first_s4;
	logic              last_s2, last_s3, last_s4;
	logic signed [8:0] cent_s2;
	logic [7:0]        gain_s2;
	logic signed [17:0] prod_s3;
	logic signed [7:0] term_s4;
	logic signed [MIX_W-1:0] mix_q;
	logic signed [MIX_W-1:0] sum_s5;
	logic [PROD_W-1:0] prod_s6;
	logic              neg_s6;

	logic        neg3;
	logic [17:0] mag3;
	logic [16:0] q3;
	logic [7:0]  tq3;
	logic signed [MIX_W-1:0] mix_sum;
	logic        neg5;
	logic [MIX_W-1:0] mag5;
	logic [7:0]  q6;
	wtom_push_t  push;

	always_comb begin
		neg3 = prod_s3[17];
		mag3 = neg3 ? 18'(-prod_s3) : 18'(prod_s3);
		q3   = (17'(mag3[14:0]) + 17'd1 + 17'(mag3[14:8])) >> 8;
		tq3  = q3[7:0];
		mix_sum = (first_s4 ? MIX_W'(0) : mix_q) + MIX_W'(term_s4);
		neg5 = sum_s5[MIX_W-1];
		mag5 = neg5 ? MIX_W'(-sum_s5) : MIX_W'(sum_s5);
		q6   = prod_s6[23:16];
		push.valid  = v_s6;
		push.sample = neg_s6 ? 8'(-$signed(q6)) : $signed(q6);
	end

	always_ff @(posedge clk) begin
		cent_s2 <= $signed({1'b0, SINE_ROM[acc_new[31:24]]}) - 9'sd128;
		gain_s2 <= gain_s1;
		prod_s3 <= 18'(cent_s2) * 18'($signed({1'b0, gain_s2}));
		term_s4 <= neg3 ? 8'(-$signed(tq3)) : $signed(tq3);
		if (v_s4) begin
			mix_q <= mix_sum;
		end
		if (v_s4 && last_s4) begin
			sum_s5 <= mix_sum;
		end
		prod_s6 <= PROD_W'(mag5) * PROD_W'(RECIP);
		neg_s6  <= neg5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
			first_s3 <= 1'b0;
			first_s4 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
			last_s3  <= 1'b0;
			last_s4  <= 1'b0;
		end else begin
			v_s1     <= iss_vld;
			first_s1 <= (iss_addr == '0);
			last_s1  <= (iss_addr == LAST_V);
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			v_s3     <= v_s2;
			first_s3 <= first_s2;
			last_s3  <= last_s2;
			v_s4     <= v_s3;
			first_s4 <= first_s3;
			last_s4  <= last_s3;
			v_s5     <= v_s4 && last_s4;
			v_s6     <= v_s5;
		end
	end

	// output buffer and credit
	logic signed [7:0] out_sample;

	assign out_pop = m_tvalid && m_tready;

	wtom_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_tready),
		.valid  (m_tvalid),
		.sample (out_sample)
	);

	assign m_tdata = {out_sample, 24'd0, out_sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({tick_acc, out_pop})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OUT_CW'(OUT_DEPTH))
		else $error("outstanding tick count above buffer depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (outstanding_q != '0))
		else $error("result offered with no tick outstanding");

	assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (busy_q == (NUM_VOICES > 1)))
		else $error("voice sequencer did not start on tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (32'(addr_s1) < NUM_VOICES))
		else $error("accumulator write beyond voice count");

endmodule
